>>> hw/rtl/lse_pkg.sv
// LED strip effect engine: shared constants, command/status structs, colour tables.
// Used by lse_ctrl, lse_dpath and led_strip_effect_engine_top.
package lse_pkg;

  localparam int NumLeds  = 64;
  localparam int GrpLen   = 7;
  localparam int FillLen  = GrpLen * (NumLeds / GrpLen);
  localparam int PatLen   = (NumLeds < 20) ? NumLeds : 20;
  localparam int BreathTop = 149;
  localparam int GradSteps = 51;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_RAINBOW = 3'd1;
  localparam logic [2:0] MODE_BREATH  = 3'd2;
  localparam logic [2:0] MODE_BULLET  = 3'd3;
  localparam logic [2:0] MODE_RESET   = MODE_BULLET;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_CALC, S_WRITE, S_SEED, S_PAT, S_CLR, S_POST, S_RD, S_EMIT
  } lse_state_t;

  typedef struct packed {
    logic cnt_clr;
    logic rb_prep;
    logic br_prep;
    logic calc_en;
    logic clr_all;
    logic wr_en;
    logic wr_pat;
    logic rb_post;
    logic br_post;
    logic bl_post;
    logic rd_en;
    logic out_load;
  } lse_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       init_pending;
    logic       calc_done;
    logic       wr_last_fill;
    logic       wr_last_pat;
    logic       rd_last;
    logic       out_free;
  } lse_sts_t;

  function automatic logic [23:0] base_rgb(input logic [2:0] idx);
    logic [23:0] v;
    unique case (idx)
      3'd0:    v = {8'd255, 8'd0,   8'd0};
      3'd1:    v = {8'd255, 8'd40,  8'd0};
      3'd2:    v = {8'd255, 8'd80,  8'd0};
      3'd3:    v = {8'd0,   8'd255, 8'd0};
      3'd4:    v = {8'd0,   8'd0,   8'd255};
      3'd5:    v = {8'd12,  8'd164, 8'd255};
      3'd6:    v = {8'd178, 8'd0,   8'd255};
      default: v = {8'd255, 8'd0,   8'd0};
    endcase
    return v;
  endfunction

  function automatic logic [23:0] pat_rgb(input logic [3:0] idx);
    logic [23:0] v;
    unique case (idx)
      4'd0:    v = {8'd255, 8'd10, 8'd40};
      4'd1:    v = {8'd51,  8'd2,  8'd8};
      4'd2:    v = {8'd17,  8'd0,  8'd2};
      4'd5:    v = {8'd0,   8'd0,  8'd255};
      4'd6:    v = {8'd0,   8'd0,  8'd51};
      4'd7:    v = {8'd0,   8'd0,  8'd31};
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/lse_ctrl.sv
// LED strip effect engine: frame sequencer state machine.
// Depends on lse_pkg; drives lse_dpath through lse_cmd_t.
module lse_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_frame_tick,
  output logic            in_stall,
  input  lse_pkg::lse_sts_t sts,
  output lse_pkg::lse_cmd_t cmd
);
  import lse_pkg::*;

  lse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_frame_tick) begin
          unique case (sts.mode)
            MODE_IDLE:    state_nxt = S_CLR;
            MODE_RAINBOW: state_nxt = S_PREP;
            MODE_BREATH:  state_nxt = S_PREP;
            MODE_BULLET:  state_nxt = sts.init_pending ? S_SEED : S_POST;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_PREP:  state_nxt = S_CALC;
      S_CALC:  if (sts.calc_done) state_nxt = S_WRITE;
      S_WRITE: if (sts.wr_last_fill) state_nxt = S_POST;
      S_SEED:  state_nxt = S_PAT;
      S_PAT:   if (sts.wr_last_pat) state_nxt = S_POST;
      S_CLR:   state_nxt = S_POST;
      S_POST:  state_nxt = S_RD;
      S_RD:    state_nxt = S_EMIT;
      S_EMIT:  if (sts.out_free && sts.rd_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: ;
      S_PREP: begin
        cmd.cnt_clr = 1'b1;
        cmd.rb_prep = (sts.mode == MODE_RAINBOW);
        cmd.br_prep = (sts.mode == MODE_BREATH);
      end
      S_CALC:  cmd.calc_en = 1'b1;
      S_WRITE: cmd.wr_en = 1'b1;
      S_SEED: begin
        cmd.clr_all = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      S_PAT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_pat = 1'b1;
      end
      S_CLR:   cmd.clr_all = 1'b1;
      S_POST: begin
        cmd.cnt_clr = 1'b1;
        cmd.rb_post = (sts.mode == MODE_RAINBOW);
        cmd.br_post = (sts.mode == MODE_BREATH);
        cmd.bl_post = (sts.mode == MODE_BULLET);
      end
      S_RD:    cmd.rd_en = 1'b1;
      S_EMIT: begin
        cmd.out_load = sts.out_free;
        cmd.rd_en    = sts.out_free && !sts.rd_last;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/lse_dpath.sv
// LED strip effect engine: pixel ring memory, effect state, colour unit, output register.
// Depends on lse_pkg; commanded by lse_ctrl.
module lse_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_write_data,
  input  lse_pkg::lse_cmd_t cmd,
  output lse_pkg::lse_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_pixel_position,
  output logic [7:0]        out_red_level,
  output logic [7:0]        out_green_level,
  output logic [7:0]        out_blue_level,
  output logic              out_last_pixel
);
  import lse_pkg::*;

  // effect state
  logic [2:0] mode_r;
  logic       init_r;
  logic [5:0] head_r;
  logic [7:0] level_r;
  logic       rising_r;
  logic [5:0] phase_r;
  logic [2:0] shift_r;

  // counters
  logic [5:0] wr_cnt_r, rd_cnt_r, data_idx_r;
  logic [2:0] grp_j_r, col_j_r;
  logic [3:0] pat_i_r;
  logic [1:0] stp_r;

  // ring memory with per-entry valid
  logic [23:0] mem [NumLeds];
  logic [NumLeds-1:0] vld_r;
  logic [23:0] rdata_r;
  logic        rvld_r;
  logic [23:0] wdata;
  logic [5:0]  waddr, raddr;

  // colour unit
  logic [23:0] col_tab_r [GrpLen];
  logic [7:0]  a_r   [3];
  logic        neg_r [3];
  logic [13:0] p_r   [3];
  logic [24:0] m_r   [3];
  logic [7:0]  res_r [3];
  logic [15:0] sq_r;
  logic [28:0] tm_r;
  logic [15:0] bp_r  [3];
  logic [23:0] col_new;

  // output register
  logic        ov_r;
  logic [5:0]  opos_r;
  logic [23:0] orgb_r;
  logic        olast_r;
  logic        out_free;

  assign out_free = !ov_r || !out_stall;
  assign waddr    = head_r + wr_cnt_r;
  assign raddr    = head_r + rd_cnt_r;
  assign wdata    = cmd.wr_pat ? pat_rgb(pat_i_r) : col_tab_r[grp_j_r];

  always_comb begin
    sts.mode         = mode_r;
    sts.init_pending = init_r;
    sts.calc_done    = (stp_r == 2'd3) && (col_j_r == 3'(GrpLen - 1));
    sts.wr_last_fill = (wr_cnt_r == 6'(FillLen - 1));
    sts.wr_last_pat  = (wr_cnt_r == 6'(PatLen - 1));
    sts.rd_last      = (data_idx_r == 6'(NumLeds - 1));
    sts.out_free     = out_free;
  end

  // effect state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RESET;
      init_r   <= 1'b1;
      head_r   <= '0;
      level_r  <= '0;
      rising_r <= 1'b0;
      phase_r  <= '0;
      shift_r  <= '0;
    end else if (cfg_write_en) begin
      mode_r <= cfg_write_data;
      init_r <= 1'b1;
    end else begin
      if (cmd.rb_prep) begin
        init_r <= 1'b0;
        if (init_r) begin
          phase_r <= '0;
          shift_r <= '0;
        end else if (phase_r >= 6'(GradSteps)) begin
          phase_r <= '0;
          shift_r <= (shift_r == 3'(GrpLen - 1)) ? 3'd0 : shift_r + 3'd1;
        end
      end
      if (cmd.br_prep && init_r) begin
        init_r   <= 1'b0;
        level_r  <= '0;
        rising_r <= 1'b1;
      end
      if (cmd.rb_post) begin
        phase_r <= phase_r + 6'd1;
        head_r  <= head_r + 6'(shift_r);
      end
      if (cmd.br_post) begin
        if (rising_r) begin
          level_r <= level_r + 8'd1;
          if (level_r + 8'd1 >= 8'(BreathTop)) rising_r <= 1'b0;
        end else begin
          level_r <= level_r - 8'd1;
          if (level_r == 8'd1) rising_r <= 1'b1;
        end
      end
      if (cmd.bl_post) begin
        head_r <= head_r + 6'd1;
        init_r <= 1'b0;
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      wr_cnt_r   <= '0;
      rd_cnt_r   <= '0;
      data_idx_r <= '0;
      grp_j_r    <= '0;
      col_j_r    <= '0;
      pat_i_r    <= '0;
      stp_r      <= '0;
    end else begin
      if (cmd.wr_en) begin
        wr_cnt_r <= wr_cnt_r + 6'd1;
        grp_j_r  <= (grp_j_r == 3'(GrpLen - 1)) ? 3'd0 : grp_j_r + 3'd1;
        pat_i_r  <= (pat_i_r == 4'd9) ? 4'd0 : pat_i_r + 4'd1;
      end
      if (cmd.rd_en) begin
        rd_cnt_r   <= rd_cnt_r + 6'd1;
        data_idx_r <= rd_cnt_r;
      end
      if (cmd.calc_en) begin
        stp_r <= stp_r + 2'd1;
        if (stp_r == 2'd3) col_j_r <= col_j_r + 3'd1;
      end
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[waddr] <= wdata;
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
      rvld_r  <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_all) vld_r <= '0;
    else if (cmd.wr_en)        vld_r[waddr] <= 1'b1;
  end

  // colour unit: four steps per group colour
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_new[23-8*c -: 8] = (mode_r == MODE_RAINBOW) ? res_r[c]
                           : 8'((bp_r[c] + 16'(bp_r[c][15:8]) + 16'd1) >> 8);
    end
  end

  always_ff @(posedge clk) begin
    logic [23:0] ca, cb;
    logic [8:0]  d;
    logic [7:0]  mag, q0, q;
    logic [13:0] rem;
    logic [7:0]  top;
    if (cmd.calc_en) begin
      ca = base_rgb(col_j_r);
      cb = base_rgb(col_j_r + 3'd1);
      top = tm_r[26:19];
      unique case (stp_r)
        2'd0: begin
          sq_r <= level_r * level_r;
          for (int c = 0; c < 3; c++) begin
            d        = {1'b0, ca[23-8*c -: 8]} - {1'b0, cb[23-8*c -: 8]};
            mag      = d[8] ? 8'(-d) : d[7:0];
            a_r[c]   <= ca[23-8*c -: 8];
            neg_r[c] <= d[8];
            p_r[c]   <= 14'(mag * phase_r);
          end
        end
        2'd1: begin
          tm_r <= 29'(sq_r * 16'd5243);
          for (int c = 0; c < 3; c++) m_r[c] <= 25'(p_r[c] * 11'd1310);
        end
        2'd2: begin
          for (int c = 0; c < 3; c++) begin
            q0 = m_r[c][23:16];
            rem = p_r[c] - 14'(q0 * 6'd50);
            q  = (rem >= 14'd50) ? q0 + 8'd1 : q0;
            res_r[c] <= neg_r[c] ? a_r[c] + q : a_r[c] - q;
            bp_r[c]  <= top * ca[23-8*c -: 8];
          end
        end
        2'd3: col_tab_r[col_j_r] <= col_new;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)              ov_r <= 1'b0;
    else if (cmd.out_load)   ov_r <= 1'b1;
    else if (!out_stall)     ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      opos_r  <= data_idx_r;
      orgb_r  <= rvld_r ? rdata_r : 24'd0;
      olast_r <= (data_idx_r == 6'(NumLeds - 1));
    end
  end

  assign out_valid          = ov_r;
  assign out_pixel_position = opos_r;
  assign out_red_level      = orgb_r[23:16];
  assign out_green_level    = orgb_r[15:8];
  assign out_blue_level     = orgb_r[7:0];
  assign out_last_pixel     = olast_r;

endmodule

>>> hw/rtl/led_strip_effect_engine_top.sv
// LED strip effect engine top level: wires the sequencer to the datapath.
// Depends on lse_pkg, lse_ctrl and lse_dpath.
//
// Each accepted frame tick applies the selected effect to a 64-pixel ring and
// then streams all 64 pixels from the ring head, one transaction per pixel,
// last_pixel marking the final one. A tick of 0 and an unknown mode give no
// output. Rainbow and breath run the shared colour unit (7 colours, 4 steps
// each) and then 63 ring writes, bullet init clears the ring and writes a
// 20-pixel pattern, and without output stall emission is limited by the
// single read port of the ring memory. Input is stalled from tick acceptance
// until the last pixel is loaded into the output register. A cfg write
// selects the effect and re-arms its init.
module led_strip_effect_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic [2:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_frame_tick,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_pixel_position,
  output logic [7:0] out_red_level,
  output logic [7:0] out_green_level,
  output logic [7:0] out_blue_level,
  output logic       out_last_pixel
);
  import lse_pkg::*;

  lse_cmd_t cmd;
  lse_sts_t sts;

  lse_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_frame_tick (in_frame_tick),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  lse_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_position (out_pixel_position),
    .out_red_level      (out_red_level),
    .out_green_level    (out_green_level),
    .out_blue_level     (out_blue_level),
    .out_last_pixel     (out_last_pixel)
  );

endmodule
